// File: design/srlb_pkg.sv
`timescale 1ns / 1ps

package srlb_pkg;

  localparam int unsigned SectorsPerClusterDef = 8;
  localparam int unsigned SlotsPerRecordDef    = 101;
  localparam int unsigned RunLimitDef          = 128;
  localparam int unsigned QueueDepthDef        = 2;

  localparam int unsigned SectorBytes = 512;
  localparam int unsigned CountField  = 128;

  typedef enum logic {
    ACT_CLUSTER = 1'b0,
    ACT_FLUSH   = 1'b1
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] start;
    logic [6:0]  count;
  } item_t;

endpackage

// File: design/srlb_front.sv
`timescale 1ns / 1ps

module srlb_front #(
  parameter int unsigned SectorsPerCluster = srlb_pkg::SectorsPerClusterDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data_i,
  input  logic                action_i,
  input  logic [27:0]         cluster_i,
  input  logic [31:0]         bytes_left_i,
  output srlb_pkg::item_t     item_o
);
  import srlb_pkg::*;

  localparam logic [31:0] CapBytes = 32'(SectorsPerCluster * SectorBytes);

  logic [31:0] data_start_q, data_start_d;
  logic [31:0] cl_off;
  logic [23:0] ceil_sum;
  logic [6:0]  sec_count;

  assign cfg_ready = 1'b1;

  always_comb begin
    data_start_d = data_start_q;
    if (cfg_valid) begin
      data_start_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= '0;
    end else begin
      data_start_q <= data_start_d;
    end
  end

  // sector count: ceil(min(bytes, cap) / 512)
  assign ceil_sum = {1'b0, bytes_left_i[31:9]} + 24'(|bytes_left_i[8:0]);

  always_comb begin
    if (bytes_left_i > CapBytes) begin
      sec_count = 7'(SectorsPerCluster);
    end else begin
      sec_count = ceil_sum[6:0];
    end
  end

  assign cl_off = {4'b0, cluster_i} - 32'd2;

  always_comb begin
    item_o.action = action_e'(action_i);
    item_o.start  = data_start_q + 32'(cl_off * 32'(SectorsPerCluster));
    item_o.count  = sec_count;
  end

endmodule

// File: design/srlb_queue.sv
`timescale 1ns / 1ps

module srlb_queue #(
  parameter int unsigned Depth = srlb_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  srlb_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output srlb_pkg::item_t item_o
);
  import srlb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && valid_o;
  assign item_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: design/srlb_back.sv
`timescale 1ns / 1ps

module srlb_back #(
  parameter int unsigned SlotsPerRecord = srlb_pkg::SlotsPerRecordDef,
  parameter int unsigned RunLimit       = srlb_pkg::RunLimitDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  srlb_pkg::item_t q_item_i,
  output logic            q_pop_o,
  input  logic            pop,
  output logic            empty,
  output logic [31:0]     run_start_sector_o,
  output logic [6:0]      run_sector_count_o,
  output logic [6:0]      slot_index_o,
  output logic [31:0]     record_index_o,
  output logic            last_o
);
  import srlb_pkg::*;

  localparam int unsigned MergeLim  = (RunLimit < CountField) ? RunLimit : CountField;
  localparam logic [8:0]  MergeLimW = 9'(MergeLim);
  localparam logic [7:0]  SlotLimit = 8'(SlotsPerRecord);

  logic        pend_valid_q, pend_valid_d;
  logic [31:0] pend_start_q, pend_start_d;
  logic [6:0]  pend_count_q, pend_count_d;
  logic [6:0]  pend_slot_q, pend_slot_d;
  logic [31:0] record_q, record_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_start_q, out_start_d;
  logic [6:0]  out_count_q, out_count_d;
  logic [6:0]  out_slot_q, out_slot_d;
  logic [31:0] out_record_q, out_record_d;
  logic        out_last_q, out_last_d;

  logic [31:0] pend_end;
  logic [8:0]  merged;
  logic        merge;
  logic        emits;
  logic        can_write;
  logic [7:0]  next_slot;

  assign pend_end  = pend_start_q + 32'(pend_count_q);
  assign merged    = 9'(pend_count_q) + 9'(q_item_i.count);
  assign merge     = pend_valid_q && (q_item_i.start == pend_end) && (merged < MergeLimW);
  assign emits     = (q_item_i.action == ACT_FLUSH) ? pend_valid_q : (pend_valid_q && !merge);
  assign can_write = !out_valid_q || pop;
  assign q_pop_o   = q_valid_i && (!emits || can_write);
  assign next_slot = {1'b0, pend_slot_q} + 8'd1;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_start_d = pend_start_q;
    pend_count_d = pend_count_q;
    pend_slot_d  = pend_slot_q;
    record_d     = record_q;
    out_valid_d  = out_valid_q && !pop;
    out_start_d  = out_start_q;
    out_count_d  = out_count_q;
    out_slot_d   = out_slot_q;
    out_record_d = out_record_q;
    out_last_d   = out_last_q;
    if (q_pop_o) begin
      if (emits) begin
        out_valid_d  = 1'b1;
        out_start_d  = pend_start_q;
        out_count_d  = pend_count_q;
        out_slot_d   = pend_slot_q;
        out_record_d = record_q;
        out_last_d   = (q_item_i.action == ACT_FLUSH);
      end
      case (q_item_i.action)
        ACT_FLUSH: begin
          pend_valid_d = 1'b0;
          pend_start_d = '0;
          pend_count_d = '0;
          pend_slot_d  = '0;
          record_d     = '0;
        end
        ACT_CLUSTER: begin
          if (merge) begin
            pend_count_d = merged[6:0];
          end else begin
            pend_valid_d = 1'b1;
            pend_start_d = q_item_i.start;
            pend_count_d = q_item_i.count;
            if (!pend_valid_q) begin
              pend_slot_d = '0;
            end else if (next_slot >= SlotLimit) begin
              pend_slot_d = '0;
              record_d    = record_q + 32'd1;
            end else begin
              pend_slot_d = next_slot[6:0];
            end
          end
        end
        default: begin
          pend_valid_d = pend_valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_start_q <= '0;
      pend_count_q <= '0;
      pend_slot_q  <= '0;
      record_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_start_q <= pend_start_d;
      pend_count_q <= pend_count_d;
      pend_slot_q  <= pend_slot_d;
      record_q     <= record_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_start_q  <= out_start_d;
    out_count_q  <= out_count_d;
    out_slot_q   <= out_slot_d;
    out_record_q <= out_record_d;
    out_last_q   <= out_last_d;
  end

  assign empty              = !out_valid_q;
  assign run_start_sector_o = out_start_q;
  assign run_sector_count_o = out_count_q;
  assign slot_index_o       = out_slot_q;
  assign record_index_o     = out_record_q;
  assign last_o             = out_last_q;

endmodule

// File: design/sector_run_list_builder.sv
`timescale 1ns / 1ps

// channel   | transfer when          | payload
// ----------+------------------------+------------------------------------------
// input     | push && !full          | action_i, cluster_i, bytes_left_i
// result    | pop && !empty          | run_start_sector_o, run_sector_count_o,
//           |                        | slot_index_o, record_index_o, last_o
// config    | cfg_valid && cfg_ready | cfg_data_i (data_start_sector)
//
// One item per cycle sustained while full stays low and results are popped; the
// result an item causes passes the item queue, then the output register,
// before it shows on the result ports. The item queue (QueueDepth entries)
// sits between the classify stage and the run merge stage; full rises once
// QueueDepth items wait behind a run that cannot leave the output register.
// Reset clears the pending run, slot, record count and data start sector.

module sector_run_list_builder #(
  parameter int unsigned SectorsPerCluster = srlb_pkg::SectorsPerClusterDef,
  parameter int unsigned SlotsPerRecord    = srlb_pkg::SlotsPerRecordDef,
  parameter int unsigned RunLimit          = srlb_pkg::RunLimitDef,
  parameter int unsigned QueueDepth        = srlb_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [27:0] cluster_i,
  input  logic [31:0] bytes_left_i,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] run_start_sector_o,
  output logic [6:0]  run_sector_count_o,
  output logic [6:0]  slot_index_o,
  output logic [31:0] record_index_o,
  output logic        last_o
);
  import srlb_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  srlb_front #(
    .SectorsPerCluster(SectorsPerCluster)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data_i  (cfg_data_i),
    .action_i    (action_i),
    .cluster_i   (cluster_i),
    .bytes_left_i(bytes_left_i),
    .item_o      (in_item)
  );

  srlb_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  srlb_back #(
    .SlotsPerRecord(SlotsPerRecord),
    .RunLimit      (RunLimit)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item),
    .q_pop_o           (q_pop),
    .pop               (pop),
    .empty             (empty),
    .run_start_sector_o(run_start_sector_o),
    .run_sector_count_o(run_sector_count_o),
    .slot_index_o      (slot_index_o),
    .record_index_o    (record_index_o),
    .last_o            (last_o)
  );

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(slot_index_o) < SlotsPerRecord))
    else $error("slot index beyond record size");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("merge stage took from an empty queue");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> q_valid)
    else $error("transferred item missing from queue");

endmodule
